// ----- rtl/core/dead_reckoning_pose_integrator_assert.svh -----
// Assertion macros shared by the pose integrator RTL.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_ASSERT_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_ASSERT_SVH

// The condition implies the property in the same cycle.
`define DRPI_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// The condition implies the property in the following cycle.
`define DRPI_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/drpi_pkg.sv -----
`default_nettype none

package drpi_pkg;

    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int ATAN_LEN = 30;
    localparam int CORDIC_W = 34;
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int OP_W = 2;
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 160;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_VEL = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_POSE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORD1,
        ST_MX1,
        ST_MX2,
        ST_MX3,
        ST_MX4,
        ST_MX5,
        ST_MX6,
        ST_QSTART,
        ST_CORD2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [CORDIC_W-1:0] cos_val;
        logic signed [CORDIC_W-1:0] sin_val;
    } cordic_rsp_t;

    function automatic logic [29:0] atan_at(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0: val = 30'd536870912;
            5'd1: val = 30'd316933405;
            5'd2: val = 30'd167458907;
            5'd3: val = 30'd85004756;
            5'd4: val = 30'd42667331;
            5'd5: val = 30'd21354465;
            5'd6: val = 30'd10680862;
            5'd7: val = 30'd5340245;
            5'd8: val = 30'd2670163;
            5'd9: val = 30'd1335086;
            5'd10: val = 30'd667544;
            5'd11: val = 30'd333772;
            5'd12: val = 30'd166886;
            5'd13: val = 30'd83443;
            5'd14: val = 30'd41721;
            5'd15: val = 30'd20860;
            5'd16: val = 30'd10430;
            5'd17: val = 30'd5215;
            5'd18: val = 30'd2607;
            5'd19: val = 30'd1303;
            5'd20: val = 30'd651;
            5'd21: val = 30'd325;
            5'd22: val = 30'd162;
            5'd23: val = 30'd81;
            5'd24: val = 30'd40;
            5'd25: val = 30'd20;
            5'd26: val = 30'd10;
            5'd27: val = 30'd5;
            5'd28: val = 30'd2;
            5'd29: val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/drpi_cordic.sv -----
`default_nettype none

module drpi_cordic #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire drpi_pkg::cordic_req_t req,
    output drpi_pkg::cordic_rsp_t rsp
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int CW = drpi_pkg::CORDIC_W;

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 flip_reg, flip_next;

    logic [31:0]          ang_plus;
    logic [31:0]          ang_adj;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] atan_val;

    always_comb begin
        ang_plus = req.angle + 32'h4000_0000;
        ang_adj = ang_plus[31] ? (req.angle + 32'h8000_0000) : req.angle;
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        atan_val = signed'({4'b0000, drpi_pkg::atan_at(5'(step_reg))});

        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;

        if (req.start) begin
            x_next = drpi_pkg::GAIN_Q30;
            y_next = '0;
            z_next = CW'(signed'(ang_adj));
            step_next = '0;
            busy_next = 1'b1;
            flip_next = ang_plus[31];
        end else if (busy_reg) begin
            if (!z_reg[CW-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        step_reg <= step_next;
        flip_reg <= flip_next;
    end

    assign rsp = '{
        done: done_reg,
        cos_val: flip_reg ? -x_reg : x_reg,
        sin_val: flip_reg ? -y_reg : y_reg
    };

endmodule

`default_nettype wire

// ----- rtl/core/drpi_mul.sv -----
`default_nettype none

module drpi_mul (
    input  wire                                    aclk,
    input  wire logic signed [drpi_pkg::MUL_A_W-1:0] a_in,
    input  wire logic signed [drpi_pkg::MUL_B_W-1:0] b_in,
    output logic signed [drpi_pkg::MUL_P_W-1:0]      p_out
);

    logic signed [drpi_pkg::MUL_P_W-1:0] p_reg, p_next;

    assign p_next = drpi_pkg::MUL_P_W'(a_in) * drpi_pkg::MUL_P_W'(b_in);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p_out = p_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dead_reckoning_pose_integrator.sv -----
`default_nettype none

// Planar dead-reckoning pose integrator. A set-velocity transaction (tuser 1) loads the
// forward speed and turn rate, and a set-pose transaction (tuser 2) loads x, y and the
// heading; neither gives a result. A tick transaction (tuser 0) advances
// the pose by speed times the cosine and sine of the old heading times dt, adds turn rate
// times dt to the heading, and returns one result with the tick count, the pose and the
// yaw quaternion of the new heading. A tick holds s_tready low through two passes of the
// shared CORDIC unit, which runs one iteration per cycle, the five products of the shared
// pipelined multiplier between them, a state that starts the second pass and a state that
// loads the output register. Unused tuser code 3 is dropped. A finished result waits in an
// output register, so new transactions are taken while it is still unread; a tick that
// finishes before that result is read waits in its output state until the output register
// is free.
module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // From bit 0 up: dt, lin_vel, ang_vel, new_x, new_y, new_heading, zero fill.
    input  wire  [drpi_pkg::S_TDATA_W-1:0]    s_tdata,
    // Bits 1:0: op.
    input  wire  [drpi_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // From bit 0 up: seq, pos_x, pos_y, heading, quat_z, quat_w.
    output logic [drpi_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int PW = drpi_pkg::MUL_P_W;
    localparam int AW = drpi_pkg::MUL_A_W;
    localparam int BW = drpi_pkg::MUL_B_W;
    localparam int CW = drpi_pkg::CORDIC_W;

    logic [19:0]        in_dt;
    logic signed [23:0] in_lin_vel;
    logic signed [31:0] in_ang_vel;
    logic [31:0]        in_new_x;
    logic [31:0]        in_new_y;
    logic [31:0]        in_new_heading;
    logic               in_accept;

    drpi_pkg::state_t   state_reg, state_next;
    logic [31:0]        x_acc_reg, x_acc_next;
    logic [31:0]        y_acc_reg, y_acc_next;
    logic [31:0]        heading_reg, heading_next;
    logic signed [23:0] speed_reg, speed_next;
    logic signed [31:0] turn_rate_reg, turn_rate_next;
    logic [31:0]        seq_count_reg, seq_count_next;
    logic [19:0]        dt_reg, dt_next;
    logic signed [AW-1:0] px_reg, px_next;
    logic signed [AW-1:0] py_reg, py_next;
    logic signed [31:0] dx_reg, dx_next;
    logic signed [31:0] dy_reg, dy_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [drpi_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    drpi_pkg::cordic_req_t cordic_req;
    drpi_pkg::cordic_rsp_t cordic_rsp;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] round36;
    logic signed [PW-1:0] round20;
    logic               out_free;
    logic               out_load;
    logic [15:0]        quat_z;
    logic [15:0]        quat_w;

    function automatic logic [31:0] sat_add(input logic [31:0] acc,
                                            input logic signed [31:0] d);
        logic signed [33:0] sum;
        sum = 34'(signed'(acc)) + 34'(d);
        if (sum > 34'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (sum < -34'sd2147483648) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    function automatic logic [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + CW'(16384)) >>> 15;
        if (r > CW'(32767)) begin
            return 16'h7FFF;
        end else if (r < -CW'(32768)) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

    assign in_dt = s_tdata[19:0];
    assign in_lin_vel = s_tdata[43:20];
    assign in_ang_vel = s_tdata[75:44];
    assign in_new_x = s_tdata[107:76];
    assign in_new_y = s_tdata[139:108];
    assign in_new_heading = s_tdata[171:140];
    assign in_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    drpi_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .rsp     (cordic_rsp)
    );

    drpi_mul u_mul (
        .aclk  (aclk),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_out (mul_p)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drpi_pkg::ST_IDLE: begin
                if (in_accept && s_tuser == drpi_pkg::OP_TICK) begin
                    state_next = drpi_pkg::ST_CORD1;
                end
            end
            drpi_pkg::ST_CORD1: begin
                if (cordic_rsp.done) begin
                    state_next = drpi_pkg::ST_MX1;
                end
            end
            drpi_pkg::ST_MX1: state_next = drpi_pkg::ST_MX2;
            drpi_pkg::ST_MX2: state_next = drpi_pkg::ST_MX3;
            drpi_pkg::ST_MX3: state_next = drpi_pkg::ST_MX4;
            drpi_pkg::ST_MX4: state_next = drpi_pkg::ST_MX5;
            drpi_pkg::ST_MX5: state_next = drpi_pkg::ST_MX6;
            drpi_pkg::ST_MX6: state_next = drpi_pkg::ST_QSTART;
            drpi_pkg::ST_QSTART: state_next = drpi_pkg::ST_CORD2;
            drpi_pkg::ST_CORD2: begin
                if (cordic_rsp.done) begin
                    state_next = drpi_pkg::ST_OUT;
                end
            end
            drpi_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = drpi_pkg::ST_IDLE;
                end
            end
            default: state_next = drpi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        cordic_req = '{start: 1'b0, angle: heading_reg};
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            drpi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cordic_req.start = in_accept && s_tuser == drpi_pkg::OP_TICK;
            end
            drpi_pkg::ST_MX1: begin
                mul_a = AW'(cordic_rsp.cos_val);
                mul_b = speed_reg;
            end
            drpi_pkg::ST_MX2: begin
                mul_a = AW'(cordic_rsp.sin_val);
                mul_b = speed_reg;
            end
            drpi_pkg::ST_MX3: begin
                mul_a = px_reg;
                mul_b = signed'({4'b0000, dt_reg});
            end
            drpi_pkg::ST_MX4: begin
                mul_a = py_reg;
                mul_b = signed'({4'b0000, dt_reg});
            end
            drpi_pkg::ST_MX5: begin
                mul_a = AW'(turn_rate_reg);
                mul_b = signed'({4'b0000, dt_reg});
            end
            drpi_pkg::ST_QSTART: begin
                cordic_req = '{start: 1'b1, angle: {1'b0, heading_reg[31:1]}};
            end
            drpi_pkg::ST_OUT: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign round36 = mul_p + (PW'(1) <<< 35);
    assign round20 = mul_p + (PW'(1) <<< 19);
    assign quat_z = to_q15(cordic_rsp.sin_val);
    assign quat_w = to_q15(cordic_rsp.cos_val);

    always_comb begin
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        heading_next = heading_reg;
        speed_next = speed_reg;
        turn_rate_next = turn_rate_reg;
        seq_count_next = seq_count_reg;
        dt_next = dt_reg;
        px_next = px_reg;
        py_next = py_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        m_tdata_next = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (in_accept) begin
            case (s_tuser)
                drpi_pkg::OP_TICK: begin
                    seq_count_next = seq_count_reg + 32'd1;
                    dt_next = in_dt;
                end
                drpi_pkg::OP_SET_VEL: begin
                    speed_next = in_lin_vel;
                    turn_rate_next = in_ang_vel;
                end
                drpi_pkg::OP_SET_POSE: begin
                    x_acc_next = in_new_x;
                    y_acc_next = in_new_y;
                    heading_next = in_new_heading;
                end
                default: begin
                    dt_next = dt_reg;
                end
            endcase
        end

        case (state_reg)
            drpi_pkg::ST_MX2: px_next = mul_p[AW+13:14];
            drpi_pkg::ST_MX3: py_next = mul_p[AW+13:14];
            drpi_pkg::ST_MX4: dx_next = round36[PW-1:36];
            drpi_pkg::ST_MX5: begin
                dy_next = round36[PW-1:36];
                x_acc_next = sat_add(x_acc_reg, dx_reg);
            end
            drpi_pkg::ST_MX6: begin
                heading_next = heading_reg + round20[51:20];
                y_acc_next = sat_add(y_acc_reg, dy_reg);
            end
            default: begin
                px_next = px_reg;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = {quat_w, quat_z, heading_reg, y_acc_reg, x_acc_reg, seq_count_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drpi_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
            heading_reg <= '0;
            speed_reg <= '0;
            turn_rate_reg <= '0;
            seq_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            x_acc_reg <= x_acc_next;
            y_acc_reg <= y_acc_next;
            heading_reg <= heading_next;
            speed_reg <= speed_next;
            turn_rate_reg <= turn_rate_next;
            seq_count_reg <= seq_count_next;
        end
        dt_reg <= dt_next;
        px_reg <= px_next;
        py_reg <= py_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

`include "dead_reckoning_pose_integrator_assert.svh"

    `DRPI_ASSERT_IMP(a_cordic_done_when_waited, cordic_rsp.done, (state_reg == drpi_pkg::ST_CORD1 || state_reg == drpi_pkg::ST_CORD2), "CORDIC finished outside a wait state")
    `DRPI_ASSERT_IMP(a_result_from_out_state, $rose(m_tvalid), ($past(state_reg) == drpi_pkg::ST_OUT), "result appeared without a finished tick")
    `DRPI_ASSERT_NXT(a_seq_only_on_tick, (in_accept && s_tuser != drpi_pkg::OP_TICK), $stable(seq_count_reg), "sequence count moved on a non-tick transaction")

endmodule

`default_nettype wire
